[sv/sks_pkg.sv]
// Package for the sum-keyed exchange sort block.
// Holds sizes, entry layout, controller states and the command/status structs.
// No dependencies.
package sks_pkg;

  localparam int MAX_CANDIDATES = 32;
  localparam int AW             = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CNT_W          = $clog2(MAX_CANDIDATES + 1);

  localparam int TAG_W      = 16;
  localparam int SCORE_W    = 8;
  localparam int KEY_W      = 10;
  localparam int ENTRY_W    = TAG_W + KEY_W;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_I,
    ST_LD_I,
    ST_SCAN,
    ST_WR_I,
    ST_EM_RD,
    ST_EM_LD
  } state_e;

  // Commands from controller to datapath, at most one active per cycle
  typedef struct packed {
    logic in_store;
    logic rd_i;
    logic ld_i;
    logic scan;
    logic wr_i;
    logic emit_rd;
    logic emit_ld;
  } cmd_t;

  typedef struct packed {
    logic one_entry;
    logic j_last;
    logic i_done;
    logic k_last;
    logic out_free;
  } sts_t;

endpackage

[sv/sks_ctrl.sv]
// Controller for the sum-keyed exchange sort block: load, sort and emit sequencing.
// Depends on sks_pkg for states and the command/status structs.
module sks_ctrl import sks_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  logic   in_last_i,
  output logic   in_ready_o,
  input  sts_t   sts_i,
  output cmd_t   cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_last_i) state_d = ST_RD_I;
      end
      ST_RD_I: begin
        state_d = sts_i.one_entry ? ST_EM_RD : ST_LD_I;
      end
      ST_LD_I: state_d = ST_SCAN;
      ST_SCAN: begin
        if (sts_i.j_last) state_d = ST_WR_I;
      end
      ST_WR_I: begin
        state_d = sts_i.i_done ? ST_EM_RD : ST_RD_I;
      end
      ST_EM_RD: state_d = ST_EM_LD;
      ST_EM_LD: begin
        if (sts_i.out_free) state_d = sts_i.k_last ? ST_IDLE : ST_EM_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.in_store  = in_valid_i;
      end
      ST_RD_I:  cmd_o.rd_i    = !sts_i.one_entry;
      ST_LD_I:  cmd_o.ld_i    = 1'b1;
      ST_SCAN:  cmd_o.scan    = 1'b1;
      ST_WR_I:  cmd_o.wr_i    = 1'b1;
      ST_EM_RD: cmd_o.emit_rd = 1'b1;
      ST_EM_LD: cmd_o.emit_ld = sts_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command active");

  a_scan_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ($past(state_q) == ST_LD_I || $past(state_q) == ST_SCAN))
    else $error("scan entered without loading row register");
`endif

endmodule

[sv/sks_dp.sv]
// Datapath for the sum-keyed exchange sort block: entry memory, counters,
// row register with compare/swap, and the output register. Depends on sks_pkg.
module sks_dp import sks_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic                  in_last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_last_o,
  output logic                  out_user_o
);

  logic [ENTRY_W-1:0] mem_q [MAX_CANDIDATES];
  logic [ENTRY_W-1:0] rdata_q;
  logic [ENTRY_W-1:0] row_q;

  logic [CNT_W-1:0] count_q, n_q;
  logic             drop_q, list_drop_q;
  logic [AW-1:0]    i_q, j_q, k_q;

  logic               out_valid_q, out_last_q, out_user_q;
  logic [ENTRY_W-1:0] out_entry_q;

  logic               full;
  logic [KEY_W-1:0]   new_key;
  logic [ENTRY_W-1:0] new_entry;
  logic               swap;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [CNT_W-1:0]   n_m1;

  assign full    = (count_q == CNT_W'(MAX_CANDIDATES));
  assign new_key = KEY_W'(in_data_i[23:16]) + KEY_W'(in_data_i[31:24])
                 + KEY_W'(in_data_i[39:32]) + KEY_W'(in_data_i[47:40]);
  assign new_entry = {in_data_i[TAG_W-1:0], new_key};
  assign n_m1      = n_q - CNT_W'(1);

  assign sts_o.one_entry = (n_q == CNT_W'(1));
  assign sts_o.j_last    = (CNT_W'(j_q) == n_m1);
  assign sts_o.i_done    = (CNT_W'(i_q) + CNT_W'(2) >= n_q);
  assign sts_o.k_last    = (CNT_W'(k_q) == n_m1);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Row i moves toward the larger key: swap when it is strictly smaller
  assign swap = cmd_i.scan && (row_q[KEY_W-1:0] < rdata_q[KEY_W-1:0]);

  assign rd_en = cmd_i.rd_i || cmd_i.ld_i || (cmd_i.scan && !sts_o.j_last) || cmd_i.emit_rd;

  always_comb begin
    if (cmd_i.rd_i) begin
      rd_addr = i_q;
    end else if (cmd_i.ld_i) begin
      rd_addr = i_q + AW'(1);
    end else if (cmd_i.scan) begin
      rd_addr = j_q + AW'(1);
    end else begin
      rd_addr = k_q;
    end
  end

  assign wr_en = (cmd_i.in_store && !full) || swap || cmd_i.wr_i;

  always_comb begin
    if (cmd_i.in_store) begin
      wr_addr = count_q[AW-1:0];
      wr_data = new_entry;
    end else if (swap) begin
      wr_addr = j_q;
      wr_data = row_q;
    end else begin
      wr_addr = i_q;
      wr_data = row_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_i || swap) row_q <= rdata_q;
    if (cmd_i.emit_ld) begin
      out_entry_q <= rdata_q;
      out_last_q  <= sts_o.k_last;
      out_user_q  <= list_drop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      n_q         <= '0;
      drop_q      <= 1'b0;
      list_drop_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.in_store) begin
        if (in_last_i) begin
          n_q         <= full ? count_q : count_q + CNT_W'(1);
          list_drop_q <= drop_q || full;
          count_q     <= '0;
          drop_q      <= 1'b0;
          i_q         <= '0;
          k_q         <= '0;
        end else if (full) begin
          drop_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (cmd_i.ld_i) j_q <= i_q + AW'(1);
      else if (cmd_i.scan && !sts_o.j_last) j_q <= j_q + AW'(1);
      if (cmd_i.wr_i) i_q <= i_q + AW'(1);
      if (cmd_i.emit_ld) k_q <= k_q + AW'(1);
      if (cmd_i.emit_ld) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{(OUT_DATA_W - ENTRY_W){1'b0}},
                        out_entry_q[KEY_W-1:0], out_entry_q[ENTRY_W-1:KEY_W]};
  assign out_last_o  = out_last_q;
  assign out_user_o  = out_user_q;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_CANDIDATES))
    else $error("entry count beyond capacity");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en && (wr_addr == rd_addr)))
    else $error("read and write of the same entry in one cycle");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_ld |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten before transfer");
`endif

endmodule

[sv/sum_keyed_exchange_sort.sv]
// Top level of the sum-keyed exchange sort block: collects records, sorts them
// by descending score sum and streams them out. Depends on sks_pkg, sks_ctrl, sks_dp.
//
//  channel  | dir | tdata                               | tlast    | tuser
//  s_axis   | in  | tag, math, physics, chem, priority  | last_in  | -
//  m_axis   | out | sorted_tag, total_key               | last_out | overflowed
//
// Loading takes one cycle per record. A list of n entries is then sorted
// with one compare per cycle while scanning, bound by the single read port
// of the entry memory; each emitted result waits for a free output register.
// No record is taken between the last record of a list and the loading of
// its final result into the output register. rst_ni clears the controller,
// counters and output valid; the entry memory is not cleared.
module sum_keyed_exchange_sort import sks_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [15:0] candidate_tag, [23:16] math_score, [31:24] physics_score,
  // [39:32] chemistry_score, [47:40] priority_score
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [15:0] sorted_tag, [25:16] total_key, [31:26] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tlast_o,
  // [0] overflowed
  output logic                  m_axis_tuser_o
);

  cmd_t cmd;
  sts_t sts;

  sks_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sks_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule
